@@ rtl/core/triangle_tangent_bitangent_assert.svh @@
// Assertion macros used by the checker module of the tangent block.
`ifndef TRIANGLE_TANGENT_BITANGENT_ASSERT_SVH
`define TRIANGLE_TANGENT_BITANGENT_ASSERT_SVH

// Checked on every rising edge while reset is low.
`define TTB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TTB_ASSERT_ALL(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/ttb_pkg.sv @@
// Types and constants of the triangle tangent and bitangent block.
package ttb_pkg;

   localparam int unsigned FieldW = 16;
   localparam int unsigned DeltaW = 17;
   localparam int unsigned ProdW  = 34;
   localparam int unsigned WideW  = 35;
   localparam int unsigned QuotW  = 32;
   localparam int unsigned FracShift = 20;
   localparam int unsigned NumTerms  = 6;

   typedef struct packed {
      logic signed [FieldW-1:0] pos_x;
      logic signed [FieldW-1:0] pos_y;
      logic signed [FieldW-1:0] pos_z;
      logic signed [FieldW-1:0] tex_u;
      logic signed [FieldW-1:0] tex_v;
   } req_type;

   typedef struct packed {
      logic signed [QuotW-1:0] tangent_x;
      logic signed [QuotW-1:0] tangent_y;
      logic signed [QuotW-1:0] tangent_z;
      logic signed [QuotW-1:0] bitangent_x;
      logic signed [QuotW-1:0] bitangent_y;
      logic signed [QuotW-1:0] bitangent_z;
      logic                    degenerate;
   } rsp_type;

   typedef struct packed {
      logic                    start;
      logic signed [WideW-1:0] num;
      logic signed [WideW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QuotW-1:0] quot;
   } div_rsp_type;

   localparam logic [QuotW-1:0] SatPos = {1'b0, {(QuotW-1){1'b1}}};
   localparam logic [QuotW-1:0] SatNeg = {1'b1, {(QuotW-1){1'b0}}};

endpackage

@@ rtl/core/ttb_mul.sv @@
// Shared signed multiplier with a registered product.
module ttb_mul (
   input  logic                                clock,
   input  logic signed [ttb_pkg::DeltaW-1:0]   a_in,
   input  logic signed [ttb_pkg::DeltaW-1:0]   b_in,
   output logic signed [ttb_pkg::ProdW-1:0]    prod
);
   import ttb_pkg::*;

   logic signed [ProdW-1:0] prod_ff;
   logic signed [ProdW-1:0] prod_in;

   always_comb begin
      prod_in = ProdW'(a_in) * ProdW'(b_in);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ rtl/core/ttb_div.sv @@
// Radix-4 restoring divider giving a saturated signed Q12.20 quotient.
module ttb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ttb_pkg::div_req_type div_req,
   output ttb_pkg::div_rsp_type div_rsp
);
   import ttb_pkg::*;

   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_LOAD = 4'b0010,
      D_ITER = 4'b0100,
      D_SAT  = 4'b1000
   } dstate_type;

   localparam int unsigned OvfW = WideW + QuotW - FracShift;

   dstate_type       state_ff, state_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [WideW-1:0] n_ff, n_in;
   logic [WideW-1:0] d_ff, d_in;
   logic             neg_ff, neg_in;
   logic             ovf_ff, ovf_in;
   logic [WideW-1:0] rem_ff, rem_in;
   logic [QuotW-1:0] sh_ff, sh_in;
   logic [QuotW-1:0] quot_ff, quot_in;

   logic [WideW:0]   t1, t2, r1, r2;
   logic             q1, q2;

   always_comb begin
      t1 = {rem_ff, sh_ff[QuotW-1]};
      q1 = (t1 >= {1'b0, d_ff});
      r1 = q1 ? (t1 - {1'b0, d_ff}) : t1;
      t2 = {r1[WideW-1:0], sh_ff[QuotW-2]};
      q2 = (t2 >= {1'b0, d_ff});
      r2 = q2 ? (t2 - {1'b0, d_ff}) : t2;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      n_in     = n_ff;
      d_in     = d_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      rem_in   = rem_ff;
      sh_in    = sh_ff;
      quot_in  = quot_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (div_req.start) begin
               n_in     = div_req.num[WideW-1] ? WideW'(-div_req.num) : WideW'(div_req.num);
               d_in     = div_req.den[WideW-1] ? WideW'(-div_req.den) : WideW'(div_req.den);
               neg_in   = div_req.num[WideW-1] ^ div_req.den[WideW-1];
               state_in = D_LOAD;
            end
         end
         D_LOAD: begin
            ovf_in   = {{(OvfW-WideW){1'b0}}, n_ff} >=
                       {d_ff, {(OvfW-WideW){1'b0}}};
            rem_in   = WideW'(n_ff[WideW-1:QuotW-FracShift]);
            sh_in    = {n_ff[QuotW-FracShift-1:0], {FracShift{1'b0}}};
            cnt_in   = 4'd15;
            state_in = D_ITER;
         end
         D_ITER: begin
            rem_in = r2[WideW-1:0];
            sh_in  = {sh_ff[QuotW-3:0], q1, q2};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = D_SAT;
            end
         end
         D_SAT: begin
            if (!neg_ff) begin
               quot_in = (ovf_ff || sh_ff[QuotW-1]) ? SatPos : sh_ff;
            end else begin
               quot_in = (ovf_ff || (sh_ff > SatNeg)) ? SatNeg : (~sh_ff + 1'b1);
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

@@ rtl/core/triangle_tangent_bitangent.sv @@
// Top level: vertex store, sequencer, shared multiplier and divider for per-triangle TBN.
// The first two vertices of a triangle are stored; the third starts the work: three
// determinant steps, then for each of six components two multiplier steps, a subtract
// and a division at two quotient bits per cycle. A zero determinant ends after the
// determinant steps. Ready is low meanwhile.
// Reset clears the vertex count, the sequencer and the result valid flag.
module triangle_tangent_bitangent (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttb_pkg::rsp_type rsp_data
);
   import ttb_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b00000001,
      S_DET_A    = 8'b00000010,
      S_DET_B    = 8'b00000100,
      S_DET_DIFF = 8'b00001000,
      S_MUL_A    = 8'b00010000,
      S_MUL_B    = 8'b00100000,
      S_DIFF     = 8'b01000000,
      S_DIV      = 8'b10000000
   } state_type;

   state_type               state_ff, state_in;
   logic [1:0]              count_ff, count_in;
   logic [2:0]              term_ff, term_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   req_type                 held_ff [2];
   logic signed [DeltaW-1:0] dp1_ff [3];
   logic signed [DeltaW-1:0] dp2_ff [3];
   logic signed [DeltaW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [ProdW-1:0] first_ff;
   logic signed [WideW-1:0] det_ff, det_in;

   logic                    accept;
   logic                    third;
   logic signed [DeltaW-1:0] mul_a, mul_b;
   logic signed [ProdW-1:0] prod;
   logic signed [WideW-1:0] diff;
   logic [1:0]              k;
   logic                    is_tan;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   function automatic logic signed [DeltaW-1:0] delta(logic signed [FieldW-1:0] a,
                                                      logic signed [FieldW-1:0] b);
      delta = DeltaW'(a) - DeltaW'(b);
   endfunction

   assign req_ready = (state_ff == S_IDLE) && !((count_ff == 2'd2) && rsp_valid_ff);
   assign accept    = req_valid && req_ready;
   assign third     = accept && (count_ff == 2'd2);

   assign is_tan = (term_ff < 3'd3);
   assign k      = is_tan ? term_ff[1:0] : 2'(term_ff - 3'd3);

   always_comb begin
      mul_a = du1_ff;
      mul_b = dv2_ff;
      unique case (state_ff)
         S_DET_B: begin
            mul_a = dv1_ff;
            mul_b = du2_ff;
         end
         S_MUL_A: begin
            mul_a = is_tan ? dp1_ff[k] : dp2_ff[k];
            mul_b = is_tan ? dv2_ff : du1_ff;
         end
         S_MUL_B: begin
            mul_a = is_tan ? dp2_ff[k] : dp1_ff[k];
            mul_b = is_tan ? dv1_ff : du2_ff;
         end
         default: begin
            mul_a = du1_ff;
            mul_b = dv2_ff;
         end
      endcase
   end

   ttb_mul u_mul (
      .clock (clock),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .prod  (prod)
   );

   assign diff = WideW'(first_ff) - WideW'(prod);

   assign div_req.start = (state_ff == S_DIFF);
   assign div_req.num   = diff;
   assign div_req.den   = det_ff;

   ttb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      term_in      = term_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      det_in       = det_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (count_ff) inside
                  2'd0, 2'd3: count_in = 2'd1;
                  2'd1:       count_in = 2'd2;
                  2'd2: begin
                     count_in = 2'd0;
                     state_in = S_DET_A;
                  end
                  default:    count_in = 2'd0;
               endcase
            end
         end
         S_DET_A: state_in = S_DET_B;
         S_DET_B: state_in = S_DET_DIFF;
         S_DET_DIFF: begin
            det_in  = diff;
            term_in = 3'd0;
            if (diff == '0) begin
               rsp_data_in  = '0;
               rsp_data_in.degenerate = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rsp_data_in.degenerate = 1'b0;
               state_in = S_MUL_A;
            end
         end
         S_MUL_A: state_in = S_MUL_B;
         S_MUL_B: state_in = S_DIFF;
         S_DIFF:  state_in = S_DIV;
         S_DIV: begin
            if (div_rsp.done) begin
               case (term_ff)
                  3'd0:    rsp_data_in.tangent_x   = div_rsp.quot;
                  3'd1:    rsp_data_in.tangent_y   = div_rsp.quot;
                  3'd2:    rsp_data_in.tangent_z   = div_rsp.quot;
                  3'd3:    rsp_data_in.bitangent_x = div_rsp.quot;
                  3'd4:    rsp_data_in.bitangent_y = div_rsp.quot;
                  default: rsp_data_in.bitangent_z = div_rsp.quot;
               endcase
               if (term_ff == 3'(NumTerms - 1)) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  term_in  = term_ff + 3'd1;
                  state_in = S_MUL_A;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      term_ff     <= term_in;
      rsp_data_ff <= rsp_data_in;
      det_ff      <= det_in;
      if (state_ff == S_DET_B || state_ff == S_MUL_B) begin
         first_ff <= prod;
      end
      if (accept && !count_ff[1]) begin
         held_ff[count_ff[0]] <= req_data;
      end else if (accept && count_ff == 2'd3) begin
         held_ff[0] <= req_data;
      end
      if (third) begin
         dp1_ff[0] <= delta(held_ff[1].pos_x, held_ff[0].pos_x);
         dp1_ff[1] <= delta(held_ff[1].pos_y, held_ff[0].pos_y);
         dp1_ff[2] <= delta(held_ff[1].pos_z, held_ff[0].pos_z);
         dp2_ff[0] <= delta(req_data.pos_x, held_ff[0].pos_x);
         dp2_ff[1] <= delta(req_data.pos_y, held_ff[0].pos_y);
         dp2_ff[2] <= delta(req_data.pos_z, held_ff[0].pos_z);
         du1_ff    <= delta(held_ff[1].tex_u, held_ff[0].tex_u);
         dv1_ff    <= delta(held_ff[1].tex_v, held_ff[0].tex_v);
         du2_ff    <= delta(req_data.tex_u, held_ff[0].tex_u);
         dv2_ff    <= delta(req_data.tex_v, held_ff[0].tex_v);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/ttb_checker.sv @@
// Port-level checker of the tangent block and its bind to the top level.
`include "triangle_tangent_bitangent_assert.svh"

module ttb_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ttb_pkg::rsp_type rsp_data
);
   import ttb_pkg::*;

   `TTB_ASSERT_ALL(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

   `TTB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   `TTB_ASSERT(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate |-> rsp_data.tangent_x == 0 && rsp_data.tangent_y == 0 && rsp_data.tangent_z == 0 && rsp_data.bitangent_x == 0 && rsp_data.bitangent_y == 0 && rsp_data.bitangent_z == 0, "degenerate result with nonzero vectors")

   `TTB_ASSERT(a_rsp_not_direct, clock, reset, $rose(rsp_valid) |-> !$past(req_valid && req_ready), "result right after an accepted item")

endmodule

bind triangle_tangent_bitangent ttb_checker u_ttb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/sv/triangle_tangent_bitangent_tb.sv @@
// Testbench for the per-triangle tangent and bitangent block: directed table, then random triangles.
module triangle_tangent_bitangent_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ttb_pkg::*;

   typedef enum int {StyleWide, StyleLocal, StyleCorner, StyleFlatUv} vertex_style_type;

   typedef struct packed {
      req_type vertex;
      bit      typed;
      rsp_type tbn;
   } directed_row_type;

   localparam rsp_type NoTbn      = '0;
   localparam rsp_type Degenerate = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1};
   localparam int      NumRows    = 21;

   localparam directed_row_type DirectedRows [NumRows] = '{
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NoTbn},
      '{'{16'h0100, 16'h0000, 16'h0000, 16'h1000, 16'h0000}, 1'b0, NoTbn},
      '{'{16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h1000}, 1'b1,
        '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 1'b0}},
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NoTbn},
      '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000}, 1'b0, NoTbn},
      '{'{16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0001}, 1'b1,
        '{SatPos, SatPos, SatPos, SatNeg, SatNeg, SatNeg, 1'b0}},
      '{'{16'h7FFF, 16'h8000, 16'h0000, 16'h8000, 16'h7FFF}, 1'b0, NoTbn},
      '{'{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF}, 1'b0, NoTbn},
      '{'{16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF}, 1'b1, Degenerate},
      '{'{16'h0100, 16'h0200, 16'h0300, 16'h0000, 16'h0000}, 1'b0, NoTbn},
      '{'{16'h0400, 16'hFE00, 16'h0000, 16'h1000, 16'h1000}, 1'b0, NoTbn},
      '{'{16'hF000, 16'h0000, 16'h0100, 16'hE000, 16'hE000}, 1'b1, Degenerate},
      '{'{16'h8000, 16'h7FFF, 16'h1234, 16'h8000, 16'h8000}, 1'b0, NoTbn},
      '{'{16'h7FFF, 16'h8000, 16'h0001, 16'h7FFF, 16'h8000}, 1'b0, NoTbn},
      '{'{16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h7FFF}, 1'b0, NoTbn},
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NoTbn},
      '{'{16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h1000}, 1'b0, NoTbn},
      '{'{16'h0000, 16'h0100, 16'h0000, 16'h1000, 16'h0000}, 1'b1,
        '{32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 1'b0}},
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NoTbn},
      '{'{16'h0001, 16'h0000, 16'hFFFF, 16'h0003, 16'h0000}, 1'b0, NoTbn},
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0003}, 1'b0, NoTbn}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          failures      = 0;
   int          vertices_sent = 0;
   int          results_seen  = 0;
   int          degenerate_count = 0;
   int          saturated_count  = 0;
   rsp_type     tbn_expected [$];
   req_type     held_vertex [2];
   int unsigned held_count = 0;

   triangle_tangent_bitangent u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [QuotW-1:0] fixed_quotient(longint num, longint den);
      longint unsigned n;
      longint unsigned d;
      longint unsigned q;
      bit              neg;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? longint'(-num) : longint'(num);
      d = (den < 0) ? longint'(-den) : longint'(den);
      q = (n << FracShift) / d;
      if (!neg) begin
         return (q > 64'h7FFF_FFFF) ? SatPos : q[QuotW-1:0];
      end
      if (q > 64'h8000_0000) begin
         q = 64'h8000_0000;
      end
      q = -q;
      return q[QuotW-1:0];
   endfunction

   task automatic predict_vertex(input req_type v, output bit produced, output rsp_type tbn);
      req_type            corner [3];
      longint             p [3][3];
      longint             tu [3];
      longint             tv [3];
      longint             dp1 [3];
      longint             dp2 [3];
      longint             du1, dv1, du2, dv2, det;
      logic [QuotW-1:0]   q [6];
      produced = 1'b0;
      tbn = '0;
      if (held_count >= 3) begin
         held_count = 0;
      end
      if (held_count < 2) begin
         held_vertex[held_count] = v;
         held_count++;
         return;
      end
      held_count = 0;
      produced = 1'b1;
      corner[0] = held_vertex[0];
      corner[1] = held_vertex[1];
      corner[2] = v;
      for (int k = 0; k < 3; k++) begin
         p[k][0] = longint'($signed(corner[k].pos_x));
         p[k][1] = longint'($signed(corner[k].pos_y));
         p[k][2] = longint'($signed(corner[k].pos_z));
         tu[k]   = longint'($signed(corner[k].tex_u));
         tv[k]   = longint'($signed(corner[k].tex_v));
      end
      for (int a = 0; a < 3; a++) begin
         dp1[a] = p[1][a] - p[0][a];
         dp2[a] = p[2][a] - p[0][a];
      end
      du1 = tu[1] - tu[0];
      dv1 = tv[1] - tv[0];
      du2 = tu[2] - tu[0];
      dv2 = tv[2] - tv[0];
      det = du1 * dv2 - dv1 * du2;
      if (det == 0) begin
         tbn.degenerate = 1'b1;
         degenerate_count++;
         return;
      end
      for (int a = 0; a < 3; a++) begin
         q[a]     = fixed_quotient(dp1[a] * dv2 - dp2[a] * dv1, det);
         q[3 + a] = fixed_quotient(dp2[a] * du1 - dp1[a] * du2, det);
      end
      tbn.tangent_x   = q[0];
      tbn.tangent_y   = q[1];
      tbn.tangent_z   = q[2];
      tbn.bitangent_x = q[3];
      tbn.bitangent_y = q[4];
      tbn.bitangent_z = q[5];
      foreach (q[i]) begin
         if (q[i] == SatPos || q[i] == SatNeg) begin
            saturated_count++;
            break;
         end
      end
   endtask

   task automatic send_vertex(input req_type vertex, input bit typed, input rsp_type typed_tbn);
      bit      produced;
      rsp_type tbn;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = vertex;
      do @(posedge clock); while (!req_ready);
      vertices_sent++;
      predict_vertex(vertex, produced, tbn);
      if (produced) begin
         tbn_expected.push_back(typed ? typed_tbn : tbn);
      end
   endtask

   function automatic logic [FieldW-1:0] pick_value(vertex_style_type style,
                                                    logic [FieldW-1:0] anchor);
      logic [FieldW-1:0] corners [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
      case (style)
         StyleLocal:  return anchor + 16'($urandom_range(1023)) - 16'd512;
         StyleCorner: return corners[$urandom_range(4)];
         default:     return 16'($urandom);
      endcase
   endfunction

   function automatic req_type make_vertex(vertex_style_type style, req_type anchor);
      req_type v;
      v.pos_x = pick_value(style, anchor.pos_x);
      v.pos_y = pick_value(style, anchor.pos_y);
      v.pos_z = pick_value(style, anchor.pos_z);
      v.tex_u = pick_value(style, anchor.tex_u);
      v.tex_v = pick_value(style, anchor.tex_v);
      return v;
   endfunction

   task automatic send_random_triangle();
      vertex_style_type style;
      vertex_style_type anchor_style;
      req_type          corner [3];
      int               pick;
      pick = $urandom_range(9);
      if (pick < 4) begin
         style = StyleWide;
      end else if (pick < 7) begin
         style = StyleLocal;
      end else if (pick < 8) begin
         style = StyleCorner;
      end else begin
         style = StyleFlatUv;
      end
      anchor_style = style;
      if (style == StyleLocal) begin
         anchor_style = StyleWide;
      end
      corner[0] = make_vertex(anchor_style, '0);
      for (int k = 1; k < 3; k++) begin
         corner[k] = make_vertex(style, corner[0]);
      end
      if (style == StyleFlatUv) begin
         pick = $urandom_range(1);
         corner[2].tex_u = corner[pick].tex_u;
         corner[2].tex_v = corner[pick].tex_v;
      end
      foreach (corner[k]) begin
         send_vertex(corner[k], 1'b0, NoTbn);
      end
   endtask

   task automatic compare_field(string name, logic signed [QuotW-1:0] want,
                                logic signed [QuotW-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (tbn_expected.size() == 0) begin
            $error("result arrived with no triangle pending");
            failures++;
         end else begin
            want = tbn_expected.pop_front();
            compare_field("tangent_x", want.tangent_x, rsp_data.tangent_x);
            compare_field("tangent_y", want.tangent_y, rsp_data.tangent_y);
            compare_field("tangent_z", want.tangent_z, rsp_data.tangent_z);
            compare_field("bitangent_x", want.bitangent_x, rsp_data.bitangent_x);
            compare_field("bitangent_y", want.bitangent_y, rsp_data.bitangent_y);
            compare_field("bitangent_z", want.bitangent_z, rsp_data.bitangent_z);
            compare_field("degenerate", 32'(want.degenerate), 32'(rsp_data.degenerate));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (2) @(negedge clock);
      reset = 1'b0;

      foreach (DirectedRows[i]) begin
         send_vertex(DirectedRows[i].vertex, DirectedRows[i].typed, DirectedRows[i].tbn);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 54 : 0;
         recv_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 29 : 0;
         repeat (106) send_random_triangle();
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (tbn_expected.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d vertices and checked %0d triangle results.", vertices_sent,
               results_seen);
      $display("Of these, %0d had a zero UV determinant and %0d hit saturation.",
               degenerate_count, saturated_count);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
